// File: hw/rtl/vbbp_pkg.sv
// Shared types and constants of the voxel bounding box bitmap packer.
`timescale 1ns / 1ps

package vbbp_pkg;

	localparam int COORD_W   = 5;   // signed cell coordinate
	localparam int PIECE_W   = 5;   // piece size register
	localparam int WORD_W    = 64;  // bitmap word
	localparam int WIDX_W    = 6;   // word index field
	localparam int BIT_W     = 6;   // bit position inside one word
	localparam int NN_W      = 10;  // square of the piece size
	localparam int LIN_W     = 15;  // linear cell bit number
	localparam int WORD_BITS = 64;
	localparam int LAST_BIT  = 63;

	localparam logic [PIECE_W-1:0] PIECE_SIZE_RST = 5'd4;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} cell_t;

	typedef enum logic [8:0] {
		ST_IDLE      = 9'b0_0000_0001,
		ST_PREP_NN   = 9'b0_0000_0010,
		ST_PREP_CNT  = 9'b0_0000_0100,
		ST_CELL_RD   = 9'b0_0000_1000,
		ST_CELL_LIN  = 9'b0_0001_0000,
		ST_BMP_RD    = 9'b0_0010_0000,
		ST_BMP_WR    = 9'b0_0100_0000,
		ST_EMIT_RD   = 9'b0_1000_0000,
		ST_EMIT_LOAD = 9'b1_0000_0000
	} state_t;

endpackage

// File: hw/rtl/vbbp_if.sv
// Channel interfaces of the voxel bounding box bitmap packer.
`timescale 1ns / 1ps

interface vbbp_cell_if
	import vbbp_pkg::*;
	;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] cell_x;
	logic signed [COORD_W-1:0] cell_y;
	logic signed [COORD_W-1:0] cell_z;
	logic                      final_cell;

	modport source (output valid, cell_x, cell_y, cell_z, final_cell, input ready);
	modport sink   (input valid, cell_x, cell_y, cell_z, final_cell, output ready);
endinterface

interface vbbp_word_if
	import vbbp_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] bitmap_word;
	logic [WIDX_W-1:0] word_index;
	logic              final_word;

	modport source (output valid, bitmap_word, word_index, final_word, input ready);
	modport sink   (input valid, bitmap_word, word_index, final_word, output ready);
endinterface

interface vbbp_cfg_if
	import vbbp_pkg::*;
	;
	logic               valid;
	logic               ready;
	logic [PIECE_W-1:0] piece_size;

	modport source (output valid, piece_size, input ready);
	modport sink   (input valid, piece_size, output ready);
endinterface

// File: hw/rtl/voxel_bounding_box_bitmap_pack.sv
// Top level: polycube cell loader, bounding box tracker and bitmap word packer.
//
// Usage: cells arrive on the cells channel, one (x, y, z) item per cell. Each
// accepted cell is written to the cell memory (up to MAX_CELLS; later cells are
// dropped) and widens a bounding box that always holds the origin. The item
// with final_cell set starts encoding: every stored cell whose bit falls inside
// the emitted words toggles one bit of a bitmap memory, and the block then sends
// floor((dy*n*n+dz*n+dx+64)/64) words (at most MAX_WORDS) on the words channel,
// the last one with final_word set. The cfg channel writes the piece size n; it
// is always ready, and the user must write it only while the block is idle; the
// block itself does not enforce this. Encoding runs a setup (piece size square
// and box size, then word count), then per stored cell a cell memory read, index
// multiply, bitmap read and bitmap write back (skipped when the cell's bit falls
// past the last word), then per word a bitmap read and an output load.
// Cells are taken only while no piece is being encoded; the last word may still
// wait in the output register while the next piece loads.
// A stalled receiver holds the output register and the emit pass waits.
// Reset clears the box, the cell count and the output valid, and sets n to 4.
`timescale 1ns / 1ps

module voxel_bounding_box_bitmap_pack
	import vbbp_pkg::*;
#(
	parameter int MAX_CELLS = 16,
	parameter int MAX_WORDS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	vbbp_cfg_if.sink     cfg,
	vbbp_cell_if.sink    cells,
	vbbp_word_if.source  words
);

	localparam int CCW  = $clog2(MAX_CELLS + 1);
	localparam int CAW  = $clog2(MAX_CELLS);
	localparam int WCW  = $clog2(MAX_WORDS + 1);
	localparam int AW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int LW_W = LIN_W - BIT_W;

	// Control state
	state_t             state_q;
	logic [PIECE_W-1:0] piece_size_q;
	logic [CCW-1:0]     cell_cnt_q;
	logic [CCW-1:0]     cell_idx_q;
	logic [WCW-1:0]     word_cnt_q;
	logic [WCW-1:0]     emit_idx_q;
	cell_t              lo_q;
	cell_t              hi_q;
	logic [MAX_WORDS-1:0] bmp_vld_q;
	logic               out_valid_q;

	// Datapath registers
	logic [NN_W-1:0]    nn_q;
	logic [COORD_W-1:0] dx_q;
	logic [COORD_W-1:0] dy_q;
	logic [COORD_W-1:0] dz_q;
	logic [LIN_W-1:0]   lin_s1;
	logic [WORD_W-1:0]  out_word_q;
	logic [WIDX_W-1:0]  out_idx_q;
	logic               out_final_q;

	// Memories
	cell_t              cell_mem [MAX_CELLS];
	cell_t              cell_rd_q;
	logic [WORD_W-1:0]  bmp_mem [MAX_WORDS];
	logic [WORD_W-1:0]  bmp_rd_q;
	logic [AW-1:0]      bmp_raddr_q;

	// Combinational signals
	logic               cells_fire;
	logic               cell_we;
	cell_t              cell_in;
	logic               cell_re;
	logic               bmp_re;
	logic               bmp_we;
	logic [AW-1:0]      bmp_raddr;
	logic [WORD_W-1:0]  bmp_cur;
	logic [WORD_W-1:0]  bmp_wdata;
	logic [BIT_W-1:0]   bit_pos;
	logic               lin_in_range;
	logic               cell_done;
	logic               cell_last;
	logic               emit_last;
	logic               out_load;
	logic [COORD_W-1:0] ox;
	logic [COORD_W-1:0] oy;
	logic [COORD_W-1:0] oz;
	logic [LIN_W-1:0]   lin_y;
	logic [NN_W-1:0]    lin_z;
	logic [LIN_W-1:0]   lin_sum;
	logic [LIN_W-1:0]   span_y;
	logic [NN_W-1:0]    span_z;
	logic [LIN_W-1:0]   span;
	logic [LW_W-1:0]    span_words;

	assign cfg.ready   = 1'b1;
	assign cells.ready = (state_q == ST_IDLE);
	assign cells_fire  = cells.valid && cells.ready;
	assign cell_in     = '{x: cells.cell_x, y: cells.cell_y, z: cells.cell_z};

	// Memory port control
	always_comb begin
		cell_we      = cells_fire && (cell_cnt_q < CCW'(MAX_CELLS));
		cell_re      = (state_q == ST_CELL_RD);
		lin_in_range = lin_s1[LIN_W-1:BIT_W] < LW_W'(word_cnt_q);
		bmp_re       = ((state_q == ST_BMP_RD) && lin_in_range) || (state_q == ST_EMIT_RD);
		bmp_raddr    = (state_q == ST_EMIT_RD) ? emit_idx_q[AW-1:0] : lin_s1[BIT_W +: AW];
		bmp_we       = (state_q == ST_BMP_WR);
		bmp_cur      = bmp_vld_q[bmp_raddr_q] ? bmp_rd_q : '0;
		bit_pos      = BIT_W'(LAST_BIT) - lin_s1[BIT_W-1:0];
		bmp_wdata    = bmp_cur ^ (WORD_W'(1) << bit_pos);
		cell_done    = ((state_q == ST_BMP_RD) && !lin_in_range) || (state_q == ST_BMP_WR);
		cell_last    = (cell_idx_q + CCW'(1)) == cell_cnt_q;
		emit_last    = (emit_idx_q + WCW'(1)) == word_cnt_q;
		out_load     = (state_q == ST_EMIT_LOAD) && (!out_valid_q || words.ready);
	end

	// Linear bit number of the cell just read
	always_comb begin
		ox      = cell_rd_q.x - lo_q.x;
		oy      = cell_rd_q.y - lo_q.y;
		oz      = cell_rd_q.z - lo_q.z;
		lin_y   = LIN_W'(oy) * LIN_W'(nn_q);
		lin_z   = NN_W'(oz) * NN_W'(piece_size_q);
		lin_sum = lin_y + LIN_W'(lin_z) + LIN_W'(ox);
	end

	// Word count of the encoding, before saturation to the bitmap depth
	always_comb begin
		span_y     = LIN_W'(dy_q) * LIN_W'(nn_q);
		span_z     = NN_W'(dz_q) * NN_W'(piece_size_q);
		span       = span_y + LIN_W'(span_z) + LIN_W'(dx_q) + LIN_W'(WORD_BITS);
		span_words = span[LIN_W-1:BIT_W];
	end

	// Cell memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem[cell_cnt_q[CAW-1:0]] <= cell_in;
		end
		if (cell_re) begin
			cell_rd_q <= cell_mem[cell_idx_q[CAW-1:0]];
		end
	end

	// Bitmap memory: write back at the address of the last read
	always_ff @(posedge clk) begin
		if (bmp_we) begin
			bmp_mem[bmp_raddr_q] <= bmp_wdata;
		end
		if (bmp_re) begin
			bmp_rd_q    <= bmp_mem[bmp_raddr];
			bmp_raddr_q <= bmp_raddr;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_PREP_NN) begin
			nn_q <= NN_W'(piece_size_q) * NN_W'(piece_size_q);
			dx_q <= hi_q.x - lo_q.x;
			dy_q <= hi_q.y - lo_q.y;
			dz_q <= hi_q.z - lo_q.z;
		end
		if (state_q == ST_CELL_LIN) begin
			lin_s1 <= lin_sum;
		end
		if (out_load) begin
			out_word_q  <= bmp_vld_q[bmp_raddr_q] ? bmp_rd_q : '0;
			out_idx_q   <= WIDX_W'(emit_idx_q);
			out_final_q <= emit_last;
		end
	end

	// Sequencer, bounds, counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			piece_size_q <= PIECE_SIZE_RST;
			cell_cnt_q   <= '0;
			cell_idx_q   <= '0;
			word_cnt_q   <= '0;
			emit_idx_q   <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			bmp_vld_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				piece_size_q <= cfg.piece_size;
			end

			// Drop the output item once taken, replace it on a load
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (words.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cells_fire) begin
						if (cell_we) begin
							cell_cnt_q <= cell_cnt_q + CCW'(1);
							if (cell_in.x < lo_q.x) lo_q.x <= cell_in.x;
							if (cell_in.y < lo_q.y) lo_q.y <= cell_in.y;
							if (cell_in.z < lo_q.z) lo_q.z <= cell_in.z;
							if (cell_in.x > hi_q.x) hi_q.x <= cell_in.x;
							if (cell_in.y > hi_q.y) hi_q.y <= cell_in.y;
							if (cell_in.z > hi_q.z) hi_q.z <= cell_in.z;
						end
						if (cells.final_cell) begin
							state_q <= ST_PREP_NN;
						end
					end
				end
				ST_PREP_NN: begin
					state_q <= ST_PREP_CNT;
				end
				ST_PREP_CNT: begin
					word_cnt_q <= (span_words > LW_W'(MAX_WORDS)) ? WCW'(MAX_WORDS)
					                                              : WCW'(span_words);
					bmp_vld_q  <= '0;
					cell_idx_q <= '0;
					state_q    <= ST_CELL_RD;
				end
				ST_CELL_RD: begin
					state_q <= ST_CELL_LIN;
				end
				ST_CELL_LIN: begin
					state_q <= ST_BMP_RD;
				end
				ST_BMP_RD: begin
					if (lin_in_range) begin
						state_q <= ST_BMP_WR;
					end
				end
				ST_BMP_WR: begin
					bmp_vld_q[bmp_raddr_q] <= 1'b1;
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LOAD;
				end
				ST_EMIT_LOAD: begin
					if (out_load) begin
						if (emit_last) begin
							state_q <= ST_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q + WCW'(1);
							state_q    <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Advance to the next cell, or clear the piece and start emitting
			if (cell_done) begin
				if (cell_last) begin
					cell_cnt_q <= '0;
					lo_q       <= '0;
					hi_q       <= '0;
					emit_idx_q <= '0;
					state_q    <= ST_EMIT_RD;
				end else begin
					cell_idx_q <= cell_idx_q + CCW'(1);
					state_q    <= ST_CELL_RD;
				end
			end
		end
	end

	assign words.valid       = out_valid_q;
	assign words.bitmap_word = out_word_q;
	assign words.word_index  = out_idx_q;
	assign words.final_word  = out_final_q;

	// The cell count never passes the memory depth
	a_cell_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cell_cnt_q <= CCW'(MAX_CELLS))
		else $error("cell count beyond cell memory depth");

	// The cell pass runs only with stored cells and a nonzero word count
	a_cell_pass_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CELL_RD |-> (cell_cnt_q != '0) && (word_cnt_q != '0))
		else $error("cell pass started without cells or words");

	// A toggle writes back only inside the emitted words
	a_toggle_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		bmp_we |-> WCW'(bmp_raddr_q) < word_cnt_q)
		else $error("bitmap write beyond the word count");

	// The piece is cleared by the time the emit pass starts
	a_piece_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT_RD |-> (cell_cnt_q == '0) && (lo_q == '0) && (hi_q == '0))
		else $error("piece state not cleared before emit");

	// A loaded word shows up on the output in the next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> words.valid && (words.final_word == $past(emit_last)))
		else $error("loaded word not presented");

endmodule
